### hdl/msta_pkg.sv
// shared types, state codes and charging helpers for microstate time accounting
package msta_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned TIME_W  = 64;

  typedef enum logic [OP_W-1:0] {
    OP_INIT   = 2'd0,
    OP_CHANGE = 2'd1,
    OP_RESTORE = 2'd2,
    OP_TERM   = 2'd3
  } op_e;

  localparam logic [STATE_W-1:0] ST_SYSTEM  = 4'd1;
  localparam logic [STATE_W-1:0] ST_TFAULT  = 4'd3;
  localparam logic [STATE_W-1:0] ST_ULOCK   = 4'd6;
  localparam logic [STATE_W-1:0] ST_SLEEP   = 4'd7;
  localparam logic [STATE_W-1:0] ST_WAITCPU = 4'd8;
  localparam logic [STATE_W-1:0] ST_STOPPED = 4'd9;
  localparam logic [STATE_W-1:0] ST_COUNT   = 4'd10;

  typedef struct packed {
    logic              sub;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic               clr;
    logic               wr_en;
    logic [STATE_W-1:0] wr_addr;
    logic [TIME_W-1:0]  wr_data;
    logic [STATE_W-1:0] rd_addr;
  } bank_req_t;

  function automatic logic is_fault_or_lock(input logic [STATE_W-1:0] s);
    return (s >= ST_TFAULT) && (s <= ST_ULOCK);
  endfunction

  function automatic logic [STATE_W-1:0] charge_slot(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0] r;
    if (is_fault_or_lock(s)) begin
      r = ST_SYSTEM;
    end else if (s < ST_COUNT) begin
      r = s;
    end else begin
      r = ST_SYSTEM;
    end
    return r;
  endfunction

endpackage

### hdl/msta_if.sv
// input and result channel interfaces
interface msta_in_if;
  import msta_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [STATE_W-1:0] state_code;
  logic [TIME_W-1:0]  now_time;
  logic [TIME_W-1:0]  enqueue_time;
  modport source (output valid, op, state_code, now_time, enqueue_time, input ready);
  modport sink (input valid, op, state_code, now_time, enqueue_time, output ready);
endinterface

interface msta_out_if;
  import msta_pkg::*;
  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] prev_state;
  logic               error;
  logic [STATE_W-1:0] acct_index;
  logic [TIME_W-1:0]  acct_total;
  logic [TIME_W-1:0]  lifetime;
  logic               last;
  modport source (output valid, prev_state, error, acct_index, acct_total, lifetime, last,
                  input ready);
  modport sink (input valid, prev_state, error, acct_index, acct_total, lifetime, last,
                output ready);
endinterface

### hdl/msta_alu.sv
// shared 64-bit add/subtract unit with registered result
module msta_alu (
  input  logic                            clk_i,
  input  msta_pkg::alu_req_t              req_i,
  output logic [msta_pkg::TIME_W-1:0]     res_o
);
  import msta_pkg::*;

  logic [TIME_W-1:0] res_q;

  always_ff @(posedge clk_i) begin
    if (req_i.sub) begin
      res_q <= req_i.a - req_i.b;
    end else begin
      res_q <= req_i.a + req_i.b;
    end
  end

  assign res_o = res_q;

endmodule

### hdl/msta_bank.sv
// per-state time totals memory with valid bits and registered read
module msta_bank #(
  parameter int unsigned NUM_STATES = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  msta_pkg::bank_req_t         req_i,
  output logic [msta_pkg::TIME_W-1:0] rdata_o
);
  import msta_pkg::*;

  localparam int unsigned AW = $clog2(NUM_STATES);

  logic [TIME_W-1:0]     mem [NUM_STATES];
  logic [NUM_STATES-1:0] vld_q;
  logic [TIME_W-1:0]     rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
    rd_q <= mem[req_i.rd_addr[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[req_i.rd_addr[AW-1:0]];
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr[AW-1:0]] <= 1'b1;
      end
    end
  end

  // entries never written since reset or init read as zero
  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

### hdl/microstate_time_accounting.sv
// microstate time accounting top level: sequencer around shared adder and totals memory
// init or refused request: result beat in the cycle after accept; one request at a time
// change: subtract, add, write; restore: that twice; terminate: change, lifetime, reads
// each accumulation takes a subtract and an add through the one shared 64-bit adder
// terminate reads the totals memory one entry per beat through its single read port
// reset: state system, previous run state system, times and all totals zero, at once
module microstate_time_accounting #(
  parameter int unsigned NUM_STATES = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  msta_in_if.sink     in_i,
  msta_out_if.source  out_o
);
  import msta_pkg::*;

  localparam int unsigned AW = $clog2(NUM_STATES);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CH_SUB,
    S_CH_ADD,
    S_CH_WR,
    S_RS_SUB1,
    S_RS_ADD1,
    S_RS_WR1,
    S_RS_SUB2,
    S_RS_ADD2,
    S_RS_WR2,
    S_TM_LIFE,
    S_TM_LIVE,
    S_TM_RD,
    S_TM_PUT,
    S_OUT
  } state_e;

  state_e             state_q;
  op_e                op_q;
  logic [STATE_W-1:0] tgt_q;
  logic [STATE_W-1:0] slot_q;
  logic [TIME_W-1:0]  now_q;
  logic [TIME_W-1:0]  enq_q;
  logic [STATE_W-1:0] cur_q;
  logic [STATE_W-1:0] prv_q;
  logic [TIME_W-1:0]  life_q;
  logic [TIME_W-1:0]  start_q;
  logic [TIME_W-1:0]  lifeo_q;
  logic [AW-1:0]      idx_q;

  logic               ov_q;
  logic [STATE_W-1:0] oprev_q;
  logic               oerr_q;
  logic [STATE_W-1:0] oidx_q;
  logic [TIME_W-1:0]  otot_q;
  logic [TIME_W-1:0]  olife_q;
  logic               olast_q;

  op_e                in_op;
  logic               accept;
  logic               bad_code;
  logic [TIME_W-1:0]  enq_eff;
  logic [STATE_W-1:0] chg_slot;
  logic [STATE_W-1:0] rs_slot;
  logic [STATE_W-1:0] rs_cur;
  logic [STATE_W-1:0] prv_after;
  logic               slot_ok;

  alu_req_t           alu_req;
  logic [TIME_W-1:0]  alu_res;
  bank_req_t          bank_req;
  logic [TIME_W-1:0]  bank_rdata;

  msta_alu u_alu (
    .clk_i (clk_i),
    .req_i (alu_req),
    .res_o (alu_res)
  );

  msta_bank #(
    .NUM_STATES (NUM_STATES)
  ) u_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (bank_req),
    .rdata_o (bank_rdata)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign in_op      = op_e'(in_i.op);
  assign bad_code   = (in_i.state_code == ST_WAITCPU) || (in_i.state_code >= ST_COUNT);
  assign enq_eff    = (in_i.enqueue_time == '0) ? in_i.now_time : in_i.enqueue_time;
  assign chg_slot   = charge_slot(cur_q);
  assign prv_after  = ((cur_q != ST_SLEEP) && (cur_q != ST_STOPPED)) ? cur_q : prv_q;
  assign slot_ok    = (int'(slot_q) < NUM_STATES);

  always_comb begin
    rs_slot = chg_slot;
    rs_cur  = cur_q;
    if (cur_q == ST_SLEEP) begin
      rs_slot = is_fault_or_lock(prv_q) ? prv_q : ST_SLEEP;
      rs_cur  = prv_q;
    end else if (cur_q == ST_STOPPED) begin
      rs_slot = ST_STOPPED;
      rs_cur  = prv_q;
    end
  end

  always_comb begin
    alu_req.sub = 1'b1;
    alu_req.a   = now_q;
    alu_req.b   = start_q;
    unique case (state_q)
      S_CH_ADD, S_RS_ADD1, S_RS_ADD2: begin
        alu_req.sub = 1'b0;
        alu_req.a   = bank_rdata;
        alu_req.b   = alu_res;
      end
      S_RS_SUB1: begin
        alu_req.a = enq_q;
        alu_req.b = start_q;
      end
      S_RS_SUB2: begin
        alu_req.a = now_q;
        alu_req.b = enq_q;
      end
      S_TM_LIFE: begin
        alu_req.a = start_q;
        alu_req.b = life_q;
      end
      default: begin
        alu_req.a = now_q;
        alu_req.b = start_q;
      end
    endcase
  end

  always_comb begin
    bank_req.clr     = accept && (in_op == OP_INIT) && !bad_code;
    bank_req.wr_en   = 1'b0;
    bank_req.wr_addr = slot_q;
    bank_req.wr_data = alu_res;
    bank_req.rd_addr = slot_q;
    unique case (state_q)
      S_CH_WR, S_RS_WR1: begin
        bank_req.wr_en = slot_ok;
      end
      S_RS_WR2: begin
        bank_req.wr_en   = 1'b1;
        bank_req.wr_addr = ST_WAITCPU;
      end
      S_RS_SUB2: begin
        bank_req.rd_addr = ST_WAITCPU;
      end
      S_TM_RD: begin
        bank_req.rd_addr = STATE_W'(idx_q);
      end
      default: begin
        bank_req.rd_addr = slot_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_INIT;
      tgt_q   <= '0;
      slot_q  <= '0;
      now_q   <= '0;
      enq_q   <= '0;
      cur_q   <= ST_SYSTEM;
      prv_q   <= ST_SYSTEM;
      life_q  <= '0;
      start_q <= '0;
      lifeo_q <= '0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
      oprev_q <= '0;
      oerr_q  <= 1'b0;
      oidx_q  <= '0;
      otot_q  <= '0;
      olife_q <= '0;
      olast_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            op_q    <= in_op;
            now_q   <= in_i.now_time;
            enq_q   <= enq_eff;
            oerr_q  <= (in_op == OP_INIT || in_op == OP_CHANGE) && bad_code;
            oidx_q  <= '0;
            otot_q  <= '0;
            olife_q <= '0;
            olast_q <= 1'b1;
            priority if ((in_op == OP_INIT || in_op == OP_CHANGE) && bad_code) begin
              oprev_q <= prv_q;
              ov_q    <= 1'b1;
              state_q <= S_OUT;
            end else if (in_op == OP_INIT) begin
              prv_q   <= ST_SYSTEM;
              life_q  <= in_i.now_time;
              start_q <= in_i.now_time;
              cur_q   <= in_i.state_code;
              oprev_q <= ST_SYSTEM;
              ov_q    <= 1'b1;
              state_q <= S_OUT;
            end else if (in_op == OP_CHANGE) begin
              tgt_q   <= in_i.state_code;
              slot_q  <= chg_slot;
              state_q <= S_CH_SUB;
            end else if (in_op == OP_RESTORE) begin
              tgt_q   <= rs_cur;
              slot_q  <= rs_slot;
              state_q <= S_RS_SUB1;
            end else begin
              tgt_q   <= ST_STOPPED;
              slot_q  <= chg_slot;
              state_q <= S_CH_SUB;
            end
          end
        end
        S_CH_SUB: state_q <= S_CH_ADD;
        S_CH_ADD: state_q <= S_CH_WR;
        S_CH_WR: begin
          cur_q   <= tgt_q;
          start_q <= now_q;
          prv_q   <= prv_after;
          if (op_q == OP_TERM) begin
            state_q <= S_TM_LIFE;
          end else begin
            oprev_q <= prv_after;
            ov_q    <= 1'b1;
            state_q <= S_OUT;
          end
        end
        S_RS_SUB1: state_q <= S_RS_ADD1;
        S_RS_ADD1: state_q <= S_RS_WR1;
        S_RS_WR1:  state_q <= S_RS_SUB2;
        S_RS_SUB2: state_q <= S_RS_ADD2;
        S_RS_ADD2: state_q <= S_RS_WR2;
        S_RS_WR2: begin
          cur_q   <= tgt_q;
          start_q <= now_q;
          oprev_q <= prv_q;
          ov_q    <= 1'b1;
          state_q <= S_OUT;
        end
        S_TM_LIFE: state_q <= S_TM_LIVE;
        S_TM_LIVE: begin
          lifeo_q <= alu_res;
          idx_q   <= '0;
          state_q <= S_TM_RD;
        end
        S_TM_RD: state_q <= S_TM_PUT;
        S_TM_PUT: begin
          oprev_q <= prv_q;
          oerr_q  <= 1'b0;
          oidx_q  <= STATE_W'(idx_q);
          otot_q  <= bank_rdata;
          olife_q <= lifeo_q;
          olast_q <= (idx_q == AW'(NUM_STATES - 1));
          ov_q    <= 1'b1;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_o.ready) begin
            ov_q <= 1'b0;
            if (olast_q) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + AW'(1);
              state_q <= S_TM_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.prev_state = oprev_q;
  assign out_o.error      = oerr_q;
  assign out_o.acct_index = oidx_q;
  assign out_o.acct_total = otot_q;
  assign out_o.lifetime   = olife_q;
  assign out_o.last       = olast_q;

endmodule

### bench/tb_top.sv
// self-checking testbench for microstate time accounting: directed table, then random traffic
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import msta_pkg::*;

  localparam int N_STATES  = 10;
  localparam int N_DIR     = 25;
  localparam int N_RANDOM  = 355;
  localparam int PAUSE_AT  = 150;
  localparam int BURST_LO  = 260;
  localparam int BURST_HI  = 330;
  localparam int HOLD_LEN  = 400;
  localparam int HOLD_AT   = 120;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [STATE_W-1:0] prev_state;
    logic               error;
    logic [STATE_W-1:0] acct_index;
    logic [TIME_W-1:0]  acct_total;
    logic [TIME_W-1:0]  lifetime;
    logic               last;
  } acct_report_t;

  typedef struct {
    op_e                op;
    logic [STATE_W-1:0] code;
    logic [TIME_W-1:0]  now;
    logic [TIME_W-1:0]  enq;
    bit                 typed;
    logic [STATE_W-1:0] t_prev;
    bit                 t_err;
  } dir_row_t;

  dir_row_t dir_tab [0:N_DIR-1] = '{
    '{OP_CHANGE,  4'd8,  64'd100,   64'd0,    1'b1, 4'd1, 1'b1},
    '{OP_INIT,    4'd15, 64'd200,   64'd0,    1'b1, 4'd1, 1'b1},
    '{OP_INIT,    4'd0,  64'd1000,  64'd0,    1'b1, 4'd1, 1'b0},
    '{OP_CHANGE,  4'd8,  64'd1100,  64'd0,    1'b1, 4'd1, 1'b1},
    '{OP_CHANGE,  4'd10, 64'd1200,  64'd0,    1'b1, 4'd1, 1'b1},
    '{OP_CHANGE,  4'd2,  64'd2000,  64'd0,    1'b0, 4'd0, 1'b0},
    '{OP_CHANGE,  4'd3,  64'd2500,  64'd0,    1'b0, 4'd0, 1'b0},
    '{OP_CHANGE,  4'd7,  64'd3000,  64'd0,    1'b0, 4'd0, 1'b0},
    '{OP_RESTORE, 4'd0,  64'd5000,  64'd4000, 1'b0, 4'd0, 1'b0},
    '{OP_CHANGE,  4'd6,  64'd5500,  64'd0,    1'b0, 4'd0, 1'b0},
    '{OP_CHANGE,  4'd7,  64'd6000,  64'd0,    1'b0, 4'd0, 1'b0},
    '{OP_RESTORE, 4'd0,  64'd7000,  64'd0,    1'b0, 4'd0, 1'b0},
    '{OP_CHANGE,  4'd9,  64'd8000,  64'd0,    1'b0, 4'd0, 1'b0},
    '{OP_RESTORE, 4'd0,  64'd9000,  64'd8500, 1'b0, 4'd0, 1'b0},
    '{OP_CHANGE,  4'd7,  64'd9500,  64'd0,    1'b0, 4'd0, 1'b0},
    '{OP_CHANGE,  4'd0,  64'd9800,  64'd0,    1'b0, 4'd0, 1'b0},
    '{OP_RESTORE, 4'd0,  64'd10000, 64'd1,    1'b0, 4'd0, 1'b0},
    '{OP_TERM,    4'd0,  64'd20000, 64'd0,    1'b0, 4'd0, 1'b0},
    '{OP_INIT,    4'd9,  ALL_ONES,  64'd0,    1'b1, 4'd1, 1'b0},
    '{OP_CHANGE,  4'd1,  64'd0,     64'd0,    1'b0, 4'd0, 1'b0},
    '{OP_RESTORE, 4'd0,  64'd0,     ALL_ONES, 1'b0, 4'd0, 1'b0},
    '{OP_TERM,    4'd15, ALL_ONES,  64'd0,    1'b0, 4'd0, 1'b0},
    '{OP_INIT,    4'd7,  64'd5,     64'd0,    1'b1, 4'd1, 1'b0},
    '{OP_RESTORE, 4'd0,  64'd50,    64'd20,   1'b0, 4'd0, 1'b0},
    '{OP_TERM,    4'd0,  64'd100,   64'd0,    1'b0, 4'd0, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  msta_in_if  in_ch ();
  msta_out_if out_ch ();

  microstate_time_accounting #(
    .NUM_STATES(N_STATES)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // thread accounting state as the block should hold it
  logic [STATE_W-1:0] run_state;
  logic [STATE_W-1:0] prev_run;
  logic [TIME_W-1:0]  life_t0;
  logic [TIME_W-1:0]  state_t0;
  logic [TIME_W-1:0]  totals [N_STATES];

  acct_report_t acct_reports_q [$];

  int fail_cnt;
  int beats_seen;
  int items_sent;
  int term_cnt;
  int refused_cnt;
  bit no_idle;
  bit hold_done;
  int hold_left;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic logic [STATE_W-1:0] sys_slot(input logic [STATE_W-1:0] s);
    if (s >= ST_TFAULT && s <= ST_ULOCK) begin
      return ST_SYSTEM;
    end
    return (s < ST_COUNT) ? s : ST_SYSTEM;
  endfunction

  function automatic void enter_state(input logic [STATE_W-1:0] target,
                                      input logic [TIME_W-1:0] now);
    logic [STATE_W-1:0] old;
    old = run_state;
    totals[sys_slot(old)] += now - state_t0;
    run_state = target;
    state_t0  = now;
    if (old != ST_SLEEP && old != ST_STOPPED) begin
      prev_run = old;
    end
  endfunction

  function automatic void charge_and_report(input op_e op, input logic [STATE_W-1:0] code,
                                            input logic [TIME_W-1:0] now,
                                            input logic [TIME_W-1:0] enq);
    logic [STATE_W-1:0] slot;
    logic [TIME_W-1:0]  e;
    logic [TIME_W-1:0]  life;
    unique case (op)
      OP_INIT, OP_CHANGE: begin
        if (code == ST_WAITCPU || code >= ST_COUNT) begin
          refused_cnt++;
          acct_reports_q.push_back('{prev_run, 1'b1, 4'd0, 64'd0, 64'd0, 1'b1});
        end else begin
          if (op == OP_INIT) begin
            prev_run  = ST_SYSTEM;
            life_t0   = now;
            state_t0  = now;
            run_state = code;
            for (int i = 0; i < N_STATES; i++) totals[i] = '0;
          end else begin
            enter_state(code, now);
          end
          acct_reports_q.push_back('{prev_run, 1'b0, 4'd0, 64'd0, 64'd0, 1'b1});
        end
      end
      OP_RESTORE: begin
        e = (enq == '0) ? now : enq;
        if (run_state == ST_SLEEP) begin
          // sleep after a fault or lock is charged to that state
          slot = (prev_run >= ST_TFAULT && prev_run <= ST_ULOCK) ? prev_run : ST_SLEEP;
          run_state = prev_run;
        end else if (run_state == ST_STOPPED) begin
          slot = ST_STOPPED;
          run_state = prev_run;
        end else begin
          slot = sys_slot(run_state);
        end
        totals[slot] += e - state_t0;
        totals[ST_WAITCPU] += now - e;
        state_t0 = now;
        acct_reports_q.push_back('{prev_run, 1'b0, 4'd0, 64'd0, 64'd0, 1'b1});
      end
      default: begin
        term_cnt++;
        enter_state(ST_STOPPED, now);
        life = state_t0 - life_t0;
        for (int i = 0; i < N_STATES; i++) begin
          acct_reports_q.push_back('{prev_run, 1'b0, STATE_W'(i), totals[i], life,
                                     (i == N_STATES - 1)});
        end
      end
    endcase
  endfunction

  task automatic send_beat(input op_e op, input logic [STATE_W-1:0] code,
                           input logic [TIME_W-1:0] now, input logic [TIME_W-1:0] enq);
    while (!no_idle && $urandom_range(0, 99) < 15) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.state_code   <= code;
    in_ch.now_time     <= now;
    in_ch.enqueue_time <= enq;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    charge_and_report(op, code, now, enq);
  endtask

  // result beats
  always @(posedge clk_i) begin
    acct_report_t got;
    acct_report_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.prev_state, out_ch.error, out_ch.acct_index, out_ch.acct_total,
              out_ch.lifetime, out_ch.last};
      beats_seen++;
      if (acct_reports_q.size() == 0) begin
        fail_cnt++;
        $display("%0t unexpected beat: prev=%0d err=%0b idx=%0d total=%h life=%h last=%0b",
                 $time, got.prev_state, got.error, got.acct_index, got.acct_total,
                 got.lifetime, got.last);
      end else begin
        want = acct_reports_q.pop_front();
        if (got !== want) begin
          fail_cnt++;
          $display("%0t mismatch expected: prev=%0d err=%0b idx=%0d total=%h life=%h last=%0b",
                   $time, want.prev_state, want.error, want.acct_index, want.acct_total,
                   want.lifetime, want.last);
          $display("%0t mismatch actual:   prev=%0d err=%0b idx=%0d total=%h life=%h last=%0b",
                   $time, got.prev_state, got.error, got.acct_index, got.acct_total,
                   got.lifetime, got.last);
        end
      end
    end
  end

  // receiver ready, with one long hold-off
  initial begin
    out_ch.ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!hold_done && beats_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    op_e                op;
    logic [STATE_W-1:0] code;
    logic [TIME_W-1:0]  t_now;
    logic [TIME_W-1:0]  enq;
    int                 r;

    in_ch.valid        = 1'b0;
    in_ch.op           = '0;
    in_ch.state_code   = '0;
    in_ch.now_time     = '0;
    in_ch.enqueue_time = '0;
    rst_ni             = 1'b0;
    fail_cnt    = 0;
    beats_seen  = 0;
    items_sent  = 0;
    term_cnt    = 0;
    refused_cnt = 0;
    no_idle     = 1'b0;
    run_state   = ST_SYSTEM;
    prev_run    = ST_SYSTEM;
    life_t0     = '0;
    state_t0    = '0;
    for (int i = 0; i < N_STATES; i++) totals[i] = '0;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int k = 0; k < N_DIR; k++) begin
      send_beat(dir_tab[k].op, dir_tab[k].code, dir_tab[k].now, dir_tab[k].enq);
      if (dir_tab[k].typed) begin
        acct_reports_q[acct_reports_q.size() - 1] =
          '{dir_tab[k].t_prev, dir_tab[k].t_err, 4'd0, 64'd0, 64'd0, 1'b1};
      end
    end

    t_now = state_t0;
    for (int k = 0; k < N_RANDOM; k++) begin
      no_idle = (k >= BURST_LO && k < BURST_HI);
      if (k == PAUSE_AT) begin
        @(negedge clk_i);
        in_ch.valid <= 1'b0;
        while (acct_reports_q.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 99) < 3) begin
        t_now = {$urandom, $urandom};
      end else begin
        t_now = t_now + TIME_W'($urandom_range(1, 5000));
      end
      code = STATE_W'($urandom_range(0, 8));
      if (code == ST_WAITCPU) code = ST_STOPPED;
      enq = '0;
      r = $urandom_range(0, 99);
      if (r < 5) begin
        op = OP_INIT;
      end else if (r < 10) begin
        op   = ($urandom_range(0, 1) != 0) ? OP_INIT : OP_CHANGE;
        code = ($urandom_range(0, 2) == 0) ? ST_WAITCPU : STATE_W'($urandom_range(10, 15));
      end else if (r < 55) begin
        op = OP_CHANGE;
      end else if (r < 85) begin
        op = OP_RESTORE;
        code = STATE_W'($urandom_range(0, 15));
        r = $urandom_range(0, 99);
        if (r < 60) begin
          enq = state_t0 + ((t_now - state_t0) >> $urandom_range(0, 8));
        end else if (r < 80) begin
          enq = {$urandom, $urandom};
        end
      end else begin
        op = OP_TERM;
        code = STATE_W'($urandom_range(0, 15));
      end
      send_beat(op, code, t_now, enq);
    end
    no_idle = 1'b0;

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (acct_reports_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (acct_reports_q.size() != 0) begin
      fail_cnt++;
      $display("%0t %0d result beats never arrived", $time, acct_reports_q.size());
    end

    $display("covered %0d items: %0d terminate reports, %0d refused requests, %0d beats",
             items_sent, term_cnt, refused_cnt, beats_seen);
    $display("with a long receiver hold-off, a drain pause and an idle-free burst");
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
